// ===== rtl/core/pinhole_point_projection_macros.svh =====
// Assertion macros shared by the pinhole point projection RTL
`ifndef PINHOLE_POINT_PROJECTION_MACROS_SVH
`define PINHOLE_POINT_PROJECTION_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define PPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/ppp_pkg.sv =====
// Shared types, constants and saturation helper for the point projection block
package ppp_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int DW         = 32;
    localparam int IDX_W      = 5;
    localparam int NUM_COEFS  = 18;
    localparam int SLOT_FX    = 12;
    localparam int SLOT_FY    = 13;
    localparam int SLOT_SKEW  = 14;
    localparam int SLOT_CX    = 15;
    localparam int SLOT_CY    = 16;
    localparam int SLOT_SCALE = 17;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_PROJECT = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int DIV_LAT    = DW + 2;
    localparam int SAT_W      = 2 * DW + 4;
    localparam int NUM_W      = DW + FRAC_BITS;

    typedef logic signed [DW-1:0]    t_word;
    typedef logic signed [2*DW-1:0]  t_prod;
    typedef logic signed [SAT_W-1:0] t_wide;

    localparam t_word WORD_MAX = t_word'({1'b0, {(DW-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(DW-1){1'b0}}});
    localparam t_wide WIDE_MAX = t_wide'(WORD_MAX);
    localparam t_wide WIDE_MIN = t_wide'(WORD_MIN);

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] coef_index;
        t_word            coef_value;
        t_word            point_x;
        t_word            point_y;
        t_word            point_z;
    } t_in_item;

    typedef struct packed {
        t_word image_x;
        t_word image_y;
        t_word depth;
        logic  depth_zero;
        logic  overflowed;
    } t_result;

    // classified item as it travels from the front queue to the back pipe
    typedef struct packed {
        logic             is_proj;
        logic             wr_en;
        logic [IDX_W-1:0] slot;
        t_word            value;
        t_word            px;
        t_word            py;
        t_word            pz;
    } t_op;

    typedef struct packed {
        t_word val;
        logic  ov;
    } t_sat;

    function automatic t_sat sat_word(input t_wide v);
        t_sat r;
        if (v > WIDE_MAX) begin
            r.val = WORD_MAX;
            r.ov  = 1'b1;
        end else if (v < WIDE_MIN) begin
            r.val = WORD_MIN;
            r.ov  = 1'b1;
        end else begin
            r.val = v[DW-1:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction
endpackage

// ===== rtl/core/ppp_front.sv =====
// Front end: accepts items, classifies them and queues them for the back pipe
`include "pinhole_point_projection_macros.svh"
module ppp_front
    import ppp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_take,
    output logic     o_valid,
    output t_op      o_op
);
    t_op                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    t_op                op_in;
    logic               push_ok;
    logic               pop_ok;

    always_comb begin
        op_in.is_proj = i_item.action == ACT_PROJECT;
        // loads beyond the last slot lose their write enable here
        op_in.wr_en   = (i_item.action == ACT_LOAD) &&
                        (i_item.coef_index < IDX_W'(NUM_COEFS));
        op_in.slot    = i_item.coef_index;
        op_in.value   = i_item.coef_value;
        op_in.px      = i_item.point_x;
        op_in.py      = i_item.point_y;
        op_in.pz      = i_item.point_z;
    end

    assign o_full  = r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_op    = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= op_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    `PPP_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, push_ok && !pop_ok, r_cnt == $past(r_cnt) + 1'b1)
    `PPP_ASSERT_NXT(a_cnt_dn, i_clk, i_rst_n, pop_ok && !push_ok, r_cnt == $past(r_cnt) - 1'b1)
endmodule

// ===== rtl/core/ppp_div.sv =====
// Pipelined signed divider: trunc(num * 2^F / den), one quotient bit per stage
module ppp_div
    import ppp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_word i_num,
    input  t_word i_den,
    output t_word o_quo,
    output logic  o_ov
);
    logic [DW-1:0]    r_rem [DW];
    logic [DW-1:0]    r_low [DW];
    logic [DW-1:0]    r_d   [DW];
    logic [DW-1:0]    r_q   [DW+1];
    logic             r_neg [DW+1];
    logic             r_pre [DW+1];
    logic [DW-1:0]    num_mag;
    logic [DW-1:0]    den_mag;
    logic [NUM_W-1:0] num_sh;
    logic [DW-1:0]    rem_in;
    t_word            n_quo;
    logic             n_ov;
    t_word            r_quo;
    logic             r_ov;
    logic [DW-1:0]    q;

    assign num_mag = i_num[DW-1] ? (~unsigned'(i_num) + 1'b1) : unsigned'(i_num);
    assign den_mag = i_den[DW-1] ? (~unsigned'(i_den) + 1'b1) : unsigned'(i_den);
    assign num_sh  = {num_mag, {FRAC_BITS{1'b0}}};
    assign rem_in  = {{(DW - FRAC_BITS){1'b0}}, num_sh[NUM_W-1 -: FRAC_BITS]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= rem_in;
            r_low[0] <= num_sh[DW-1:0];
            r_d[0]   <= den_mag;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[DW-1] ^ i_den[DW-1];
            // quotient would need more than DW bits
            r_pre[0] <= rem_in >= den_mag;
        end
    end

    for (genvar k = 1; k <= DW; k++) begin : g_step
        logic [DW:0] part;
        logic [DW:0] diff;
        logic        ge;

        assign part = {r_rem[k-1], r_low[k-1][DW-1]};
        assign diff = part - {1'b0, r_d[k-1]};
        assign ge   = part >= {1'b0, r_d[k-1]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]   <= {r_q[k-1][DW-2:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_pre[k] <= r_pre[k-1];
            end
        end

        if (k < DW) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[DW-1:0] : part[DW-1:0];
                    r_low[k] <= {r_low[k-1][DW-2:0], 1'b0};
                    r_d[k]   <= r_d[k-1];
                end
            end
        end
    end

    assign q = r_q[DW];

    always_comb begin
        n_quo = q;
        n_ov  = 1'b0;
        if (r_pre[DW]) begin
            n_quo = r_neg[DW] ? WORD_MIN : WORD_MAX;
            n_ov  = 1'b1;
        end else if (r_neg[DW]) begin
            if (q > unsigned'(WORD_MIN)) begin
                n_quo = WORD_MIN;
                n_ov  = 1'b1;
            end else begin
                n_quo = ~q + 1'b1;
            end
        end else if (q[DW-1]) begin
            n_quo = WORD_MAX;
            n_ov  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo <= n_quo;
            r_ov  <= n_ov;
        end
    end

    assign o_quo = r_quo;
    assign o_ov  = r_ov;
endmodule

// ===== rtl/core/ppp_back.sv =====
// Back end: coefficient table, camera transform, perspective divide, intrinsics
`include "pinhole_point_projection_macros.svh"
module ppp_back
    import ppp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_op     i_op,
    output logic    o_valid,
    output t_result o_result
);
    typedef struct packed {
        t_word z;
        logic  zero;
        logic  ov;
        t_word fxe;
        t_word fye;
        t_word ske;
        t_word cx;
        t_word cy;
    } t_side;

    t_word   r_coef [NUM_COEFS];

    logic    r1_v;
    t_prod   r1_m [9];
    t_prod   r1_e [3];
    t_word   r1_t [3];
    t_word   r1_cx;
    t_word   r1_cy;

    logic    r2_v;
    t_wide   r2_sum [3];
    t_sat    r2_eff [3];
    t_word   r2_t [3];
    t_word   r2_cx;
    t_word   r2_cy;

    logic    r3_v;
    t_sat    r3_cam [3];
    t_sat    r3_eff [3];
    t_word   r3_cx;
    t_word   r3_cy;

    t_side   side_in;
    t_side   r_sb [DIV_LAT];
    logic    r_sv [DIV_LAT];
    t_side   sb;
    t_side   sb_div;
    t_word   u;
    t_word   v;
    logic    u_ov;
    logic    v_ov;

    logic    r5_v;
    t_prod   r5_ux;
    t_prod   r5_vs;
    t_prod   r5_vy;
    t_side   r5_sb;

    logic    r6_v;
    t_wide   r6_sx;
    t_wide   r6_sy;
    t_side   r6_sb;

    t_sat    sat_x;
    t_sat    sat_y;
    logic    r_v;
    t_result r_res;

    function automatic t_prod smul(input t_word a, input t_word b);
        return a * b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_en && i_valid && i_op.wr_en) begin
            r_coef[i_op.slot] <= i_op.value;
        end
    end

    // stage 1: all products of the transform and the scaled intrinsics
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r1_m[3*r]   <= smul(r_coef[4*r],     i_op.px);
                r1_m[3*r+1] <= smul(r_coef[4*r+1],   i_op.py);
                r1_m[3*r+2] <= smul(r_coef[4*r+2],   i_op.pz);
                r1_t[r]     <= r_coef[4*r+3];
            end
            r1_e[0] <= smul(r_coef[SLOT_FX],   r_coef[SLOT_SCALE]);
            r1_e[1] <= smul(r_coef[SLOT_FY],   r_coef[SLOT_SCALE]);
            r1_e[2] <= smul(r_coef[SLOT_SKEW], r_coef[SLOT_SCALE]);
            r1_cx   <= r_coef[SLOT_CX];
            r1_cy   <= r_coef[SLOT_CY];
        end
    end

    // stage 2: exact row sums, scaled intrinsics floored and clamped
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r2_sum[r] <= t_wide'(r1_m[3*r]) + t_wide'(r1_m[3*r+1])
                           + t_wide'(r1_m[3*r+2]);
                r2_eff[r] <= sat_word(t_wide'(r1_e[r]) >>> FRAC_BITS);
                r2_t[r]   <= r1_t[r];
            end
            r2_cx <= r1_cx;
            r2_cy <= r1_cy;
        end
    end

    // stage 3: camera coordinates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < 3; r++) begin
                r3_cam[r] <= sat_word((r2_sum[r] >>> FRAC_BITS) + t_wide'(r2_t[r]));
                r3_eff[r] <= r2_eff[r];
            end
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
        end
    end

    always_comb begin
        side_in.z    = r3_cam[2].val;
        side_in.zero = r3_cam[2].val == '0;
        side_in.ov   = r3_cam[0].ov | r3_cam[1].ov | r3_cam[2].ov
                     | r3_eff[0].ov | r3_eff[1].ov | r3_eff[2].ov;
        side_in.fxe  = r3_eff[0].val;
        side_in.fye  = r3_eff[1].val;
        side_in.ske  = r3_eff[2].val;
        side_in.cx   = r3_cx;
        side_in.cy   = r3_cy;
    end

    ppp_div u_div_u (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r3_cam[0].val),
        .i_den (r3_cam[2].val),
        .o_quo (u),
        .o_ov  (u_ov)
    );

    ppp_div u_div_v (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r3_cam[1].val),
        .i_den (r3_cam[2].val),
        .o_quo (v),
        .o_ov  (v_ov)
    );

    // side data rides alongside the dividers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sb[0] <= side_in;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r_v  <= 1'b0;
        end else if (i_en) begin
            r1_v    <= i_valid && i_op.is_proj;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r_sv[0] <= r3_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r5_v <= r_sv[DIV_LAT-1];
            r6_v <= r5_v;
            r_v  <= r6_v;
        end
    end

    assign sb = r_sb[DIV_LAT-1];

    // divider overflow folds into the side flag
    always_comb begin
        sb_div    = sb;
        sb_div.ov = sb.ov | u_ov | v_ov;
    end

    // stage 5: intrinsic products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ux <= smul(u, sb.fxe);
            r5_vs <= smul(v, sb.ske);
            r5_vy <= smul(v, sb.fye);
            r5_sb <= sb_div;
        end
    end

    // stage 6: column sum formed exactly before the floor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_sx <= t_wide'(r5_ux) + t_wide'(r5_vs);
            r6_sy <= t_wide'(r5_vy);
            r6_sb <= r5_sb;
        end
    end

    assign sat_x = sat_word((r6_sx >>> FRAC_BITS) + t_wide'(r6_sb.cx));
    assign sat_y = sat_word((r6_sy >>> FRAC_BITS) + t_wide'(r6_sb.cy));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r6_sb.zero) begin
                r_res.image_x    <= '0;
                r_res.image_y    <= '0;
                r_res.depth      <= '0;
                r_res.depth_zero <= 1'b1;
                r_res.overflowed <= 1'b0;
            end else begin
                r_res.image_x    <= sat_x.val;
                r_res.image_y    <= sat_y.val;
                r_res.depth      <= r6_sb.z;
                r_res.depth_zero <= 1'b0;
                r_res.overflowed <= r6_sb.ov | sat_x.ov | sat_y.ov;
            end
        end
    end

    assign o_valid  = r_v;
    assign o_result = r_res;

    `PPP_ASSERT_IMP(a_zero_clean, i_clk, i_rst_n, r_v && r_res.depth_zero, r_res.image_x == '0 && r_res.image_y == '0 && !r_res.overflowed)
    `PPP_ASSERT_NXT(a_load_no_res, i_clk, i_rst_n, i_en && i_valid && !i_op.is_proj, !r1_v)
endmodule

// ===== rtl/core/pinhole_point_projection.sv =====
// Top level of the pinhole point projection block
//
//  channel   handshake          payload    direction
//  item      push / full        i_item     in   (load coefficient or project point)
//  result    pop / empty        o_result   out  (one beat per project item)
//
// One item is accepted per cycle while the queue is not full; a load returns nothing,
// a project returns one beat. A result passes through the queue, three transform
// stages, the dividers, three intrinsic stages and the output register.
// Reset clears the coefficient table and all valid state.
// A result waiting on the output register stalls the back pipe; the 4-entry front
// queue keeps taking items until it fills.
module pinhole_point_projection
    import ppp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output logic     empty,
    input  logic     pop,
    output t_result  o_result
);
    logic    en;
    logic    q_valid;
    t_op     q_op;
    logic    b_valid;
    t_result b_result;
    logic    r_out_v;
    t_result r_out;

    // back pipe advances whenever the output register can take a beat
    assign en = !r_out_v || pop;

    ppp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (en),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    ppp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (q_valid),
        .i_op     (q_op),
        .o_valid  (b_valid),
        .o_result (b_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= b_result;
        end
    end

    assign empty    = !r_out_v;
    assign o_result = r_out;
endmodule

// ===== verif/ppp_checker.sv =====
// Checker for the point projection block: predicts results and compares beats
module ppp_checker
    import ppp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    input  logic     full,
    input  t_in_item i_item,
    input  logic     empty,
    input  logic     pop,
    input  t_result  o_result,
    output int       o_fail_count,
    output int       o_pending,
    output int       o_beats_seen
);
    t_word   coef_table [NUM_COEFS];
    t_result expected_beats [$];

    function automatic longint floor_frac(input longint v);
        return v >>> FRAC_BITS;
    endfunction

    function automatic longint clamp_word(input longint v, inout bit ov);
        if (v > 64'sd2147483647) begin
            ov = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            ov = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Products stay within 2^62 but their sums can pass 2^63, so sums are
    // kept in a wider signed type before the arithmetic shift floors them.
    function automatic t_result project_point(input t_in_item it);
        t_result res;
        longint cam [3];
        longint p [3];
        longint fxe, fye, ske, u, v, ix, iy;
        t_wide acc;
        t_wide sx;
        bit ov;
        ov = 1'b0;
        p[0] = longint'(it.point_x);
        p[1] = longint'(it.point_y);
        p[2] = longint'(it.point_z);
        for (int r = 0; r < 3; r++) begin
            acc = '0;
            for (int c = 0; c < 3; c++)
                acc += t_wide'(longint'(coef_table[r*4+c]) * p[c]);
            cam[r] = clamp_word(longint'(acc >>> FRAC_BITS)
                                + longint'(coef_table[r*4+3]), ov);
        end
        res = '0;
        if (cam[2] == 0) begin
            res.depth_zero = 1'b1;
            return res;
        end
        fxe = clamp_word(floor_frac(longint'(coef_table[SLOT_FX])
                                    * longint'(coef_table[SLOT_SCALE])), ov);
        fye = clamp_word(floor_frac(longint'(coef_table[SLOT_FY])
                                    * longint'(coef_table[SLOT_SCALE])), ov);
        ske = clamp_word(floor_frac(longint'(coef_table[SLOT_SKEW])
                                    * longint'(coef_table[SLOT_SCALE])), ov);
        u = clamp_word((cam[0] <<< FRAC_BITS) / cam[2], ov);
        v = clamp_word((cam[1] <<< FRAC_BITS) / cam[2], ov);
        sx = t_wide'(u*fxe) + t_wide'(v*ske);
        ix = clamp_word(longint'(sx >>> FRAC_BITS) + longint'(coef_table[SLOT_CX]), ov);
        iy = clamp_word(floor_frac(v*fye) + longint'(coef_table[SLOT_CY]), ov);
        res.image_x    = t_word'(ix);
        res.image_y    = t_word'(iy);
        res.depth      = t_word'(cam[2]);
        res.overflowed = ov;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (coef_table[k]) coef_table[k] <= '0;
            expected_beats.delete();
            o_fail_count <= 0;
            o_beats_seen <= 0;
        end else begin
            if (pop && !empty) begin
                o_beats_seen <= o_beats_seen + 1;
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_beats.pop_front();
                    if (o_result !== want) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_result.image_x !== want.image_x)
                            $error("image_x exp %h got %h", want.image_x, o_result.image_x);
                        if (o_result.image_y !== want.image_y)
                            $error("image_y exp %h got %h", want.image_y, o_result.image_y);
                        if (o_result.depth !== want.depth)
                            $error("depth exp %h got %h", want.depth, o_result.depth);
                        if (o_result.depth_zero !== want.depth_zero)
                            $error("depth_zero exp %b got %b", want.depth_zero,
                                   o_result.depth_zero);
                        if (o_result.overflowed !== want.overflowed)
                            $error("overflowed exp %b got %b", want.overflowed,
                                   o_result.overflowed);
                    end
                end
            end
            if (push && !full) begin
                if (i_item.action == ACT_PROJECT)
                    expected_beats.push_back(project_point(i_item));
                else if (i_item.coef_index < NUM_COEFS)
                    coef_table[i_item.coef_index] <= i_item.coef_value;
            end
        end
    end

    assign o_pending = expected_beats.size();
endmodule

// ===== verif/testbench.sv =====
// Testbench top: drives load and project items and reports the verdict
module testbench;
    import ppp_pkg::*;

    logic     i_clk;
    logic     i_rst_n;
    logic     push;
    logic     full;
    t_in_item i_item;
    logic     empty;
    logic     pop = 1'b0;
    t_result  o_result;
    int       fail_count;
    int       pending;
    int       beats_seen;
    int       items_sent;
    int       projects_sent;

    pinhole_point_projection u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_item, .empty, .pop, .o_result
    );

    ppp_checker u_checker (
        .i_clk, .i_rst_n, .push, .full, .i_item, .empty, .pop, .o_result,
        .o_fail_count(fail_count), .o_pending(pending), .o_beats_seen(beats_seen)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // receiver stall pattern: phases of always-ready and of random stalls
    int pop_phase = 0;
    always @(negedge i_clk) begin
        pop_phase <= pop_phase + 1;
        if ((pop_phase / 200) % 3 == 0)
            pop <= 1'b1;
        else if ((pop_phase / 200) % 3 == 1)
            pop <= ($urandom_range(0, 3) != 0);
        else
            pop <= ($urandom_range(0, 7) == 0);
    end

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return t_word'($urandom);
            3: return t_word'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
            4: return t_word'(32'h10000 * ($urandom_range(0, 8) - 4));
            default: return t_word'($urandom_range(0, 32'hfffff)) - 32'sh80000;
        endcase
    endfunction

    // one beat on the input side: hold until accepted
    task automatic send_item(input t_in_item it);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        @(negedge i_clk);
        items_sent++;
        if (it.action == ACT_PROJECT) projects_sent++;
    endtask

    task automatic idle_cycles(input int n);
        push <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic load_coef(input int slot, input t_word val);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.action     = ACT_LOAD;
        it.coef_index = slot[IDX_W-1:0];
        it.coef_value = val;
        send_item(it);
    endtask

    task automatic project(input t_word x, input t_word y, input t_word z);
        t_in_item it;
        it = t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.action  = ACT_PROJECT;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        send_item(it);
    endtask

    // a plausible camera: near-identity rotation, modest focal lengths
    task automatic load_sane_camera();
        for (int k = 0; k < 12; k++)
            load_coef(k, (k % 5 == 0) ? 32'sh10000
                         : t_word'($urandom_range(0, 32'h2000)) - 32'sh1000);
        load_coef(SLOT_FX, t_word'($urandom_range(32'h100000, 32'h4000000)));
        load_coef(SLOT_FY, t_word'($urandom_range(32'h100000, 32'h4000000)));
        load_coef(SLOT_SKEW, t_word'($urandom_range(0, 32'h4000)) - 32'sh2000);
        load_coef(SLOT_CX, t_word'($urandom_range(0, 32'h2800000)));
        load_coef(SLOT_CY, t_word'($urandom_range(0, 32'h1e00000)));
        load_coef(SLOT_SCALE, t_word'($urandom_range(32'h8000, 32'h20000)));
    endtask

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int kind;
        t_word zv;
        push          = 1'b0;
        i_item        = '0;
        i_rst_n       = 1'b0;
        items_sent    = 0;
        projects_sent = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero table gives depth zero, then extremes and bad slots
        project(32'sh7fffffff, 32'sh80000000, 32'sh10000);
        for (int k = 0; k < NUM_COEFS; k++) load_coef(k, 32'sh7fffffff);
        load_coef(18, 32'sh12345678);
        load_coef(31, 32'sh80000000);
        project(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        project(32'sh80000000, 32'sh80000000, 32'sh80000000);
        project(32'sh0, 32'sh0, 32'sh0);
        load_sane_camera();
        project(32'sh10000, 32'sh20000, 32'sh40000);
        project(32'sh0, 32'sh0, 32'sh0);
        project(32'sh7fffffff, 32'sh80000000, 32'sh1);

        // random: mostly sane cameras with points in front, some wild loads
        while (items_sent < 1870) begin
            if ($urandom_range(0, 15) == 0) load_sane_camera();
            repeat ($urandom_range(1, 24)) begin
                kind = $urandom_range(0, 19);
                if (kind == 0)
                    load_coef($urandom_range(0, 31), rand_word());
                else if (kind == 1)
                    project(rand_word(), rand_word(), rand_word());
                else begin
                    zv = t_word'($urandom_range(0, 32'h400000)) + 32'sh8000;
                    project(t_word'($urandom_range(0, 32'h400000)) - 32'sh200000,
                            t_word'($urandom_range(0, 32'h400000)) - 32'sh200000,
                            ($urandom_range(0, 9) == 0) ? -zv : zv);
                end
            end
            if ($urandom_range(0, 1)) idle_cycles($urandom_range(1, 12));
            if ($urandom_range(0, 60) == 0) begin
                push <= 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
        end
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);

        $display("Run covered %0d items, %0d projections, %0d result beats checked.",
                 items_sent, projects_sent, beats_seen);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ppp_pkg.sv
rtl/core/ppp_front.sv
rtl/core/ppp_div.sv
rtl/core/ppp_back.sv
rtl/core/pinhole_point_projection.sv
verif/ppp_checker.sv
verif/testbench.sv
